// ===== rtl/core/bucketed_hash_table_engine_defines.svh =====
// ---------------------------------------------------------------------------
// Hash table engine assertion macros
// Shared assertion shorthand for the engine's checks.
// ---------------------------------------------------------------------------
`ifndef BUCKETED_HASH_TABLE_ENGINE_DEFINES_SVH
`define BUCKETED_HASH_TABLE_ENGINE_DEFINES_SVH

// property that holds outside reset
`define BHT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// antecedent followed next cycle by consequent, outside reset
`define BHT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bht_pkg.sv =====
// ---------------------------------------------------------------------------
// Hash table package
// Status codes, command kinds and the front-to-back request record.
// ---------------------------------------------------------------------------
`default_nettype none
package bht_pkg;
   localparam logic [2:0] ST_BUCKET   = 3'd0;
   localparam logic [2:0] ST_OVERFLOW = 3'd1;
   localparam logic [2:0] ST_DROPPED  = 3'd2;
   localparam logic [2:0] ST_HIT      = 3'd3;
   localparam logic [2:0] ST_MISS     = 3'd4;
   localparam logic       KIND_INSERT = 1'b0;
   localparam logic       KIND_LOOKUP = 1'b1;
   localparam logic [31:0] HASH_MULT  = 32'd2654435769;

   typedef struct packed {
      logic        kind;
      logic [30:0] key;
      logic [63:0] payload;
      logic [5:0]  bucket_to_search;
   } item_type;
endpackage
`default_nettype wire

// ===== rtl/core/bht_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module bht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/bht_front.sv =====
// ---------------------------------------------------------------------------
// Hash table front end
// Accepts items into a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module bht_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire bht_pkg::item_type in_item,
   output logic                   q_valid,
   input  wire logic              q_pop,
   output bht_pkg::item_type      q_item
);
   import bht_pkg::*;
   item_type   buf_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = buf_ff[rd_ff];
   assign rd_in    = rd_ff ^ q_pop;
   assign wr_in    = wr_ff ^ push;
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wr_ff] <= in_item;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/bht_back.sv =====
// ---------------------------------------------------------------------------
// Hash table back end
// Hashes, scans bucket slots one after another, writes records, forms results.
// ---------------------------------------------------------------------------
`default_nettype none
module bht_back #(
   parameter int TABLE_BUCKETS     = 64,
   parameter int BLOCKS_PER_BUCKET = 4,
   parameter int ENTRIES_PER_BLOCK = 4,
   parameter int OVERFLOW_DEPTH    = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire bht_pkg::item_type q_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [2:0]             out_status,
   output logic [5:0]             out_bucket,
   output logic [7:0]             out_opos,
   output logic [63:0]            out_payload
);
   import bht_pkg::*;
   localparam int BW  = (TABLE_BUCKETS > 1) ? $clog2(TABLE_BUCKETS) : 1;
   localparam int KW  = (BLOCKS_PER_BUCKET > 1) ? $clog2(BLOCKS_PER_BUCKET) : 1;
   localparam int EW  = (ENTRIES_PER_BLOCK > 1) ? $clog2(ENTRIES_PER_BLOCK) : 1;
   localparam int FW  = $clog2(ENTRIES_PER_BLOCK + 1);
   localparam int NBLK = TABLE_BUCKETS * BLOCKS_PER_BUCKET;
   localparam int NSLT = NBLK * ENTRIES_PER_BLOCK;
   localparam int BKW = $clog2(NBLK) > 0 ? $clog2(NBLK) : 1;
   localparam int SW  = $clog2(NSLT) > 0 ? $clog2(NSLT) : 1;
   localparam int OW  = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
   localparam int UW  = $clog2(OVERFLOW_DEPTH + 1);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_HASH   = 8'b00000010,
      S_BUCKET = 8'b00000100,
      S_READ   = 8'b00001000,
      S_FILL   = 8'b00010000,
      S_SCAN   = 8'b00100000,
      S_CMP    = 8'b01000000,
      S_OUT    = 8'b10000000
   } state_type;

   state_type      state_ff, state_in;
   item_type       it_ff;
   logic [31:0]    prod_ff;
   logic [BW-1:0]  bkt_ff;
   logic [KW-1:0]  blk_ff;
   logic [EW-1:0]  ent_ff;
   logic [BKW-1:0] clr_ff;
   logic           clr_done_ff;
   logic [UW-1:0]  used_ff;
   logic [TABLE_BUCKETS-1:0] ovf_seen_ff;
   logic [2:0]     st_ff;
   logic [7:0]     opos_ff;
   logic [63:0]    pay_ff;
   logic [5:0]     bo_ff;
   logic           scan_ok_ff;

   logic [BKW-1:0] fc_raddr, fc_waddr;
   logic [FW-1:0]  fc_rdata, fc_wdata;
   logic           fc_we;
   logic           sl_we, ov_we;
   logic [SW-1:0]  sl_waddr, sl_raddr;
   logic [94:0]    sl_rdata, ov_rdata;
   logic [BKW-1:0] cur_blk;
   logic           last_blk, has_room, ovf_room, more_slots, key_match;

   assign cur_blk    = BKW'(32'(bkt_ff) * BLOCKS_PER_BUCKET + 32'(blk_ff));
   assign last_blk   = (blk_ff == KW'(BLOCKS_PER_BUCKET - 1));
   assign has_room   = (fc_rdata < FW'(ENTRIES_PER_BLOCK));
   assign ovf_room   = (used_ff < UW'(OVERFLOW_DEPTH));
   assign more_slots = (32'(ent_ff) + 32'd1 < 32'(fc_rdata));
   assign key_match  = (sl_rdata[94:64] == it_ff.key);

   bht_ram #(.WIDTH(FW), .DEPTH(NBLK)) u_fill (
      .clock, .wr_en(fc_we), .wr_addr(fc_waddr), .wr_data(fc_wdata),
      .rd_addr(fc_raddr), .rd_data(fc_rdata));
   bht_ram #(.WIDTH(95), .DEPTH(NSLT)) u_slot (
      .clock, .wr_en(sl_we), .wr_addr(sl_waddr), .wr_data({it_ff.key, it_ff.payload}),
      .rd_addr(sl_raddr), .rd_data(sl_rdata));
   bht_ram #(.WIDTH(95), .DEPTH(OVERFLOW_DEPTH)) u_ovf (
      .clock, .wr_en(ov_we), .wr_addr(used_ff[OW-1:0]),
      .wr_data({it_ff.key, it_ff.payload}), .rd_addr(used_ff[OW-1:0]),
      .rd_data(ov_rdata));

   assign q_pop     = (state_ff == S_IDLE) && q_valid && clr_done_ff;
   assign out_valid = (state_ff == S_OUT);
   assign out_status = st_ff;
   assign out_bucket = bo_ff;
   assign out_opos   = opos_ff;
   assign out_payload = pay_ff;

   always_comb begin
      fc_raddr = cur_blk;
      fc_we    = 1'b0;
      fc_waddr = cur_blk;
      fc_wdata = fc_rdata + FW'(1);
      sl_we    = 1'b0;
      sl_waddr = SW'(32'(cur_blk) * ENTRIES_PER_BLOCK + 32'(fc_rdata));
      sl_raddr = SW'(32'(cur_blk) * ENTRIES_PER_BLOCK + 32'(ent_ff));
      ov_we    = 1'b0;
      if (!clr_done_ff) begin
         fc_we    = 1'b1;
         fc_waddr = clr_ff;
         fc_wdata = '0;
      end else if (state_ff == S_FILL && it_ff.kind == KIND_INSERT) begin
         if (has_room) begin
            fc_we = 1'b1;
            sl_we = 1'b1;
         end else if (last_blk && ovf_room) begin
            ov_we = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (q_pop) state_in = S_HASH;
         S_HASH:   state_in = S_BUCKET;
         S_BUCKET: state_in = S_READ;
         S_READ:   state_in = S_FILL;
         S_FILL: begin
            if (it_ff.kind == KIND_INSERT) begin
               if (has_room || last_blk) state_in = S_OUT;
               else state_in = S_READ;
            end else if (!scan_ok_ff) begin
               state_in = S_OUT;
            end else if (fc_rdata != '0) begin
               state_in = S_CMP;
            end else if (last_blk) begin
               state_in = S_OUT;
            end else begin
               state_in = S_READ;
            end
         end
         S_SCAN:   state_in = S_CMP;
         S_CMP: begin
            if (key_match) state_in = S_OUT;
            else if (more_slots) state_in = S_SCAN;
            else if (last_blk) state_in = S_OUT;
            else state_in = S_READ;
         end
         S_OUT:    if (out_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         used_ff     <= '0;
         ovf_seen_ff <= '0;
      end else begin
         if (!clr_done_ff) begin
            clr_ff <= clr_ff + BKW'(1);
            if (clr_ff == BKW'(NBLK - 1)) clr_done_ff <= 1'b1;
         end
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               it_ff <= q_item;
            end
            S_HASH: begin
               prod_ff <= {1'b0, it_ff.key} * HASH_MULT;
            end
            S_BUCKET: begin
               blk_ff <= '0;
               ent_ff <= '0;
               opos_ff <= '0;
               pay_ff <= '0;
               if (it_ff.kind == KIND_INSERT) begin
                  bkt_ff <= BW'(({32'd0, prod_ff} * 64'(TABLE_BUCKETS)) >> 32);
                  bo_ff  <= 6'(({32'd0, prod_ff} * 64'(TABLE_BUCKETS)) >> 32);
               end else begin
                  bkt_ff <= BW'(it_ff.bucket_to_search);
                  bo_ff  <= it_ff.bucket_to_search;
               end
               scan_ok_ff <= (32'(it_ff.bucket_to_search) < 32'(TABLE_BUCKETS));
            end
            S_FILL: begin
               // fill count of current block valid now
               if (it_ff.kind == KIND_INSERT) begin
                  if (has_room) begin
                     st_ff <= ST_BUCKET;
                  end else if (!last_blk) begin
                     blk_ff <= blk_ff + KW'(1);
                  end else if (ovf_room) begin
                     opos_ff <= 8'(used_ff);
                     used_ff <= used_ff + UW'(1);
                     ovf_seen_ff[bkt_ff] <= 1'b1;
                     st_ff <= ST_OVERFLOW;
                  end else begin
                     st_ff <= ST_DROPPED;
                  end
               end else if (!scan_ok_ff) begin
                  st_ff <= ST_MISS;
               end else if (fc_rdata == '0) begin
                  if (last_blk) st_ff <= ST_MISS;
                  else blk_ff <= blk_ff + KW'(1);
               end
            end
            S_CMP: begin
               if (key_match) begin
                  pay_ff <= sl_rdata[63:0];
                  st_ff <= ST_HIT;
               end else if (more_slots) begin
                  ent_ff <= ent_ff + EW'(1);
               end else if (last_blk) begin
                  st_ff <= ST_MISS;
               end else begin
                  blk_ff <= blk_ff + KW'(1);
                  ent_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/bucketed_hash_table_engine.sv =====
// ---------------------------------------------------------------------------
// Bucketed hash table engine
// Multiplicative-hash bucketed record store with shared overflow area.
// ---------------------------------------------------------------------------
// channel  dir  fields
// req      in   tdata: kind, key, payload, bucket_to_search
// rsp      out  tdata: status, bucket_index, overflow_position, found_payload
// Insert: the result beat follows the first block with room; else overflow or drop.
// Lookup: empty blocks are skipped, else slots are compared in turn until a key hit.
// After reset the fill counts are cleared, one block a cycle.
// A two-beat queue holds requests while the back end is busy.
// ---------------------------------------------------------------------------
`default_nettype none
module bucketed_hash_table_engine #(
   parameter int TABLE_BUCKETS     = 64,
   parameter int BLOCKS_PER_BUCKET = 4,
   parameter int ENTRIES_PER_BLOCK = 4,
   parameter int OVERFLOW_DEPTH    = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [103:0] req_tdata,  // kind, key, payload, bucket_to_search, pad
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [87:0]       rsp_tdata   // status, bucket_index, overflow_position, found_payload
);
   `include "bucketed_hash_table_engine_defines.svh"
   import bht_pkg::*;
   item_type    in_item, q_item;
   logic        q_valid, q_pop;
   logic [2:0]  st;
   logic [5:0]  bo;
   logic [7:0]  op;
   logic [63:0] pay;

   assign in_item.kind             = req_tdata[0];
   assign in_item.key              = req_tdata[31:1];
   assign in_item.payload          = req_tdata[95:32];
   assign in_item.bucket_to_search = req_tdata[101:96];
   assign rsp_tdata = {7'd0, pay, op, bo, st};

   bht_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item, .q_valid, .q_pop, .q_item);
   bht_back #(.TABLE_BUCKETS(TABLE_BUCKETS), .BLOCKS_PER_BUCKET(BLOCKS_PER_BUCKET),
      .ENTRIES_PER_BLOCK(ENTRIES_PER_BLOCK), .OVERFLOW_DEPTH(OVERFLOW_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item, .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_status(st), .out_bucket(bo), .out_opos(op),
      .out_payload(pay));

   `BHT_ASSERT(a_status_range, rsp_tvalid |-> (st <= ST_MISS), "bad status")
   `BHT_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "held")
   `BHT_ASSERT(a_opos, rsp_tvalid && st != ST_OVERFLOW |-> op == 8'd0, "stray overflow position")
endmodule
`default_nettype wire

// ===== tb/sv/bucketed_hash_table_engine_test.sv =====
// ---------------------------------------------------------------------------
// Bucketed hash table engine testbench
// Drives insert and lookup beats and predicts each response from a local
// model of the bucket slots and the overflow fill. Random keys are aimed
// at a few buckets so that the overflow store fills and then drops.
// ---------------------------------------------------------------------------
`default_nettype none
module bucketed_hash_table_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bht_pkg::*;

   localparam int BUCKETS    = 64;
   localparam int BLOCKS     = 4;
   localparam int ENTRIES    = 4;
   localparam int OVF_DEPTH  = 256;
   localparam int NUM_RANDOM = 530;
   localparam int MAX_CYCLES = 400000;

   typedef struct {
      logic [2:0]  status;
      logic [5:0]  bucket_index;
      logic [7:0]  overflow_position;
      logic [63:0] found_payload;
   } answer_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [103:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [87:0]   rsp_tdata;
   logic          req_tready_seen = 1'b0;

   item_type      pending_items[$];
   answer_type    expected_answers[$];
   logic [30:0]   stored_keys[$];
   int            phase = 0;
   int            sent_count = 0;
   int            cycle_count = 0;
   bit            failed = 1'b0;

   logic [30:0]   table_key[BUCKETS*BLOCKS*ENTRIES];
   logic [63:0]   table_payload[BUCKETS*BLOCKS*ENTRIES];
   int            block_fill[BUCKETS*BLOCKS];
   int            overflow_fill;

   bucketed_hash_table_engine uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [5:0] home_bucket(logic [30:0] key);
      logic [63:0] product;
      product = {33'd0, key} * {32'd0, HASH_MULT};
      return product[31:26];
   endfunction

   function automatic answer_type table_step(item_type it);
      answer_type a;
      int bi;
      int si;
      bit done;
      a.overflow_position = '0;
      a.found_payload = '0;
      done = 1'b0;
      if (it.kind == KIND_INSERT) begin
         a.bucket_index = home_bucket(it.key);
         for (int blk = 0; blk < BLOCKS && !done; blk++) begin
            bi = a.bucket_index * BLOCKS + blk;
            if (block_fill[bi] < ENTRIES) begin
               si = bi * ENTRIES + block_fill[bi];
               table_key[si] = it.key;
               table_payload[si] = it.payload;
               block_fill[bi]++;
               done = 1'b1;
            end
         end
         if (done) begin
            a.status = ST_BUCKET;
         end else if (overflow_fill < OVF_DEPTH) begin
            a.overflow_position = overflow_fill[7:0];
            overflow_fill++;
            a.status = ST_OVERFLOW;
         end else begin
            a.status = ST_DROPPED;
         end
      end else begin
         a.bucket_index = it.bucket_to_search;
         for (int blk = 0; blk < BLOCKS && !done; blk++) begin
            bi = it.bucket_to_search * BLOCKS + blk;
            for (int e = 0; e < block_fill[bi] && !done; e++) begin
               si = bi * ENTRIES + e;
               if (table_key[si] == it.key) begin
                  a.found_payload = table_payload[si];
                  done = 1'b1;
               end
            end
         end
         a.status = done ? ST_HIT : ST_MISS;
      end
      return a;
   endfunction

   function automatic logic [30:0] key_for_bucket(logic [5:0] b);
      logic [30:0] k;
      k = 31'($urandom());
      while (home_bucket(k) != b) k = 31'($urandom());
      return k;
   endfunction

   task automatic queue_item(logic kind, logic [30:0] key, logic [63:0] payload,
                             logic [5:0] bucket);
      item_type it;
      it.kind = kind;
      it.key = key;
      it.payload = payload;
      it.bucket_to_search = bucket;
      pending_items.push_back(it);
      if (kind == KIND_INSERT) stored_keys.push_back(key);
   endtask

   // stimulus
   initial begin
      logic [5:0]  hot[3];
      logic [30:0] k;
      logic [63:0] p;
      int          r;
      for (int i = 0; i < 3; i++) hot[i] = 6'($urandom_range(0, BUCKETS - 1));
      queue_item(KIND_LOOKUP, 31'd0, 64'd0, 6'd0);
      queue_item(KIND_LOOKUP, 31'h7FFFFFFF, '1, 6'd63);
      queue_item(KIND_INSERT, 31'd0, 64'd0, 6'd63);
      queue_item(KIND_INSERT, 31'h7FFFFFFF, '1, 6'd0);
      queue_item(KIND_LOOKUP, 31'd0, '1, home_bucket(31'd0));
      queue_item(KIND_LOOKUP, 31'h7FFFFFFF, 64'd0, home_bucket(31'h7FFFFFFF));
      queue_item(KIND_LOOKUP, 31'h7FFFFFFF, 64'd0, home_bucket(31'h7FFFFFFF) ^ 6'd1);
      queue_item(KIND_INSERT, 31'h7FFFFFFF, 64'h0123456789ABCDEF, 6'd0);
      queue_item(KIND_LOOKUP, 31'h7FFFFFFF, 64'd0, home_bucket(31'h7FFFFFFF));
      queue_item(KIND_LOOKUP, 31'h12345678, 64'd0, 6'd0);
      queue_item(KIND_LOOKUP, 31'h2AAAAAAA, 64'd0, 6'd63);
      queue_item(KIND_INSERT, 31'h55555555, 64'hAAAAAAAAAAAAAAAA, 6'd0);
      queue_item(KIND_INSERT, 31'h2AAAAAAA, 64'h5555555555555555, 6'd63);
      queue_item(KIND_LOOKUP, 31'h55555555, 64'd0, home_bucket(31'h55555555));
      queue_item(KIND_LOOKUP, 31'h2AAAAAAA, 64'd0, home_bucket(31'h2AAAAAAA));
      for (int i = 0; i < 5; i++) begin
         k = key_for_bucket(hot[0]);
         queue_item(KIND_INSERT, k, {$urandom(), $urandom()}, 6'($urandom()));
      end
      for (int n = 0; n < NUM_RANDOM; n++) begin
         r = $urandom_range(0, 99);
         p = {$urandom(), $urandom()};
         if (r < 70) begin
            if (r < 55) k = key_for_bucket(hot[$urandom_range(0, 2)]);
            else if (r < 62) k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else k = 31'($urandom());
            queue_item(KIND_INSERT, k, p, 6'($urandom()));
         end else begin
            if (r < 85) begin
               k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
               queue_item(KIND_LOOKUP, k, p, home_bucket(k));
            end else if (r < 92) begin
               k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
               queue_item(KIND_LOOKUP, k, p, 6'($urandom()));
            end else begin
               queue_item(KIND_LOOKUP, 31'($urandom()), p, 6'($urandom()));
            end
         end
      end
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (pending_items.size() == 0 && !req_tvalid);
      wait (expected_answers.size() == 0);
      repeat (60) @(posedge clock);
      if (!failed && expected_answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // driver
   always @(negedge clock) begin
      int total;
      total = NUM_RANDOM + 20;
      phase <= (sent_count < total / 3) ? 0 : (sent_count < 2 * total / 3) ? 1 : 2;
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (pending_items.size() != 0 &&
                !(phase == 0 && $urandom_range(0, 99) < 16) &&
                !(phase == 1 && $urandom_range(0, 99) < 83)) begin
               req_tdata <= {2'b00, pending_items[0].bucket_to_search,
                             pending_items[0].payload, pending_items[0].key,
                             pending_items[0].kind};
               void'(pending_items.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         case (phase)
            0: rsp_tready <= ($urandom_range(0, 99) >= 83);
            1: rsp_tready <= ($urandom_range(0, 99) >= 16);
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      item_type   it;
      answer_type got;
      answer_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
      if (reset) begin
         for (int i = 0; i < BUCKETS * BLOCKS; i++) block_fill[i] = 0;
         overflow_fill = 0;
         req_tready_seen <= 1'b0;
      end else begin
         req_tready_seen <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            it.kind = req_tdata[0];
            it.key = req_tdata[31:1];
            it.payload = req_tdata[95:32];
            it.bucket_to_search = req_tdata[101:96];
            expected_answers.push_back(table_step(it));
            sent_count <= sent_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[2:0];
            got.bucket_index = rsp_tdata[8:3];
            got.overflow_position = rsp_tdata[16:9];
            got.found_payload = rsp_tdata[80:17];
            if (expected_answers.size() == 0) begin
               $display("%0t unexpected beat: expected none, got %h", $realtime, rsp_tdata);
               failed = 1'b1;
            end else begin
               want = expected_answers.pop_front();
               if (got.status != want.status ||
                   got.bucket_index != want.bucket_index ||
                   got.overflow_position != want.overflow_position ||
                   got.found_payload != want.found_payload) begin
                  $display("%0t mismatch: expected st=%0d bkt=%0d ovf=%0d pay=%h",
                           $realtime, want.status, want.bucket_index,
                           want.overflow_position, want.found_payload);
                  $display("%0t            actual st=%0d bkt=%0d ovf=%0d pay=%h",
                           $realtime, got.status, got.bucket_index,
                           got.overflow_position, got.found_payload);
                  failed = 1'b1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire
